@@ rtl/core/multi_reader_ring_backlog_defines.svh @@
// Assertion macros shared by the RTL of the ring backlog.
`ifndef MULTI_READER_RING_BACKLOG_DEFINES_SVH
`define MULTI_READER_RING_BACKLOG_DEFINES_SVH

// Checked on every clock edge outside reset.
`define MRRB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define MRRB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/core/mrrb_pkg.sv @@
`timescale 1ns / 1ps
package mrrb_pkg;
  localparam int RING_BYTES = 4096;
  localparam int READERS    = 8;
  localparam int LIMIT_MAX  = 64;
  localparam int PTR_W      = $clog2(RING_BYTES);
  localparam int FILL_W     = PTR_W + 1;
  localparam int RIDX_W     = $clog2(READERS);
  localparam int OFS_W      = 48;
  localparam int LEN_W      = 20;
  localparam int LIM_W      = 7;
  localparam int CNT_W      = 4;

  typedef enum logic [2:0] {
    ACT_CMD    = 3'd0,
    ACT_BYTE   = 3'd1,
    ACT_DRAIN  = 3'd2,
    ACT_ATTACH = 3'd3,
    ACT_STREAM = 3'd4,
    ACT_DETACH = 3'd5,
    ACT_REPORT = 3'd6,
    ACT_COUNT  = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    KIND_DONE  = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_EVICT = 2'd2,
    KIND_COUNT = 2'd3
  } kind_e;
endpackage

@@ rtl/core/mrrb_ram.sv @@
`timescale 1ns / 1ps
module mrrb_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

@@ rtl/core/multi_reader_ring_backlog.sv @@
`timescale 1ns / 1ps
// Byte backlog ring shared by eight reader slots.
// The input channel (in_valid_i/in_ready_o) takes one item per action; the
// output channel (out_valid_o/out_ready_i) returns its result items, the
// final one flagged by last_o. cfg_we_i writes the drain limit at once.
// Byte appends, attach, detach, set streaming and report ack are done on
// acceptance and return their single item from the registered output.
// A drain returns its bytes one at a time, each read from the ring RAM in
// ST_DRD and registered in ST_DLAT, up to the drain limit per item.
// A command start of nonzero length below the ring size scans the reader slots
// one per cycle, then compacts the ring in two steps, ST_COMP1 and ST_COMP2.
// A synced count scans the slots the same way, then returns its count from ST_CRESP.
// Only one item is in work at a time; a new item is taken when the block is
// idle and the output register is free or being emptied.
// When the receiver stalls, the output item is held and the block waits.
// Reset empties the ring and all reader slots and sets the drain limit to
// 64; the ring RAM needs no clearing, since no byte is read before written.
`include "multi_reader_ring_backlog_defines.svh"
module multi_reader_ring_backlog import mrrb_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [2:0]             action_i,
  input  logic [2:0]             reader_i,
  input  logic [7:0]             data_byte_i,
  input  logic [LEN_W-1:0]       command_length_i,
  input  logic [OFS_W-1:0]       offset_value_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [1:0]             kind_o,
  output logic [7:0]             out_byte_o,
  output logic                   last_o,
  output logic [CNT_W-1:0]       synced_count_o,
  output logic [READERS-1:0]     evicted_mask_o,
  input  logic                   cfg_we_i,
  input  logic [LIM_W-1:0]       cfg_wdata_i
);
  typedef enum logic [7:0] {
    ST_IDLE  = 8'b00000001,
    ST_SCAN  = 8'b00000010,
    ST_COMP1 = 8'b00000100,
    ST_COMP2 = 8'b00001000,
    ST_CNT   = 8'b00010000,
    ST_CRESP = 8'b00100000,
    ST_DRD   = 8'b01000000,
    ST_DLAT  = 8'b10000000
  } state_e;

  state_e state_q, state_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [OFS_W-1:0]  base_q, base_d, head_q, head_d;
  logic [OFS_W-1:0]  acked_q [READERS];
  logic [OFS_W-1:0]  acked_d [READERS];
  logic [OFS_W-1:0]  rep_q [READERS];
  logic [OFS_W-1:0]  rep_d [READERS];
  logic [READERS-1:0] stream_q, stream_d, dead_q, dead_d, pres_q, pres_d;
  logic [LIM_W-1:0]  limit_q, limit_d;

  logic [RIDX_W-1:0] idx_q, idx_d, rsel_q, rsel_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [OFS_W-1:0]  after_q, after_d, min_q, min_d, ofs_q, ofs_d;
  logic              any_live_q, any_live_d, any_pres_q, any_pres_d;
  logic [READERS-1:0] macc_q, macc_d;
  logic [CNT_W-1:0]  cacc_q, cacc_d;
  logic [LIM_W-1:0]  n_q, n_d, k_q, k_d;
  logic [PTR_W-1:0]  pos_q, pos_d;

  logic              ov_q, ov_d;
  kind_e             kind_q, kind_d;
  logic [7:0]        ob_q, ob_d;
  logic              last_q, last_d;
  logic [CNT_W-1:0]  sc_q, sc_d;
  logic [READERS-1:0] em_q, em_d;

  logic              ram_we, ram_re;
  logic [PTR_W-1:0]  ram_raddr;
  logic [7:0]        ram_rdata;

  logic              can_put, accept;
  logic [READERS-1:0] live;
  logic [LIM_W-1:0]  lim;
  logic [OFS_W-1:0]  acc_r, lag, dlt, skip, lagk;
  logic [FILL_W-1:0] drop;
  logic [LEN_W:0]    sum;

  assign can_put    = !ov_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && can_put;
  assign accept     = in_valid_i && in_ready_o;
  assign live       = pres_q & ~dead_q & stream_q;

  always_comb begin
    if (limit_q == '0) begin
      lim = LIM_W'(1);
    end else if (limit_q > LIM_W'(LIMIT_MAX)) begin
      lim = LIM_W'(LIMIT_MAX);
    end else begin
      lim = limit_q;
    end
  end

  always_comb begin
    state_d = state_q; rd_ptr_d = rd_ptr_q; wr_ptr_d = wr_ptr_q; fill_d = fill_q;
    base_d = base_q; head_d = head_q; acked_d = acked_q; rep_d = rep_q;
    stream_d = stream_q; dead_d = dead_q; pres_d = pres_q;
    limit_d = cfg_we_i ? cfg_wdata_i : limit_q;
    idx_d = idx_q; rsel_d = rsel_q; len_d = len_q; after_d = after_q; min_d = min_q;
    ofs_d = ofs_q; any_live_d = any_live_q; any_pres_d = any_pres_q; macc_d = macc_q;
    cacc_d = cacc_q; n_d = n_q; k_d = k_q; pos_d = pos_q;
    ov_d = ov_q && !out_ready_i; kind_d = kind_q; ob_d = ob_q; last_d = last_q;
    sc_d = sc_q; em_d = em_q;
    ram_we = 1'b0; ram_re = 1'b0; ram_raddr = pos_q;
    acc_r = acked_q[reader_i];
    lag = head_q - acc_r;
    skip = acc_r - base_q;
    lagk = after_q - acked_q[idx_q];
    dlt = min_q - base_q;
    drop = '0;
    sum = (LEN_W + 1)'(fill_q) + (LEN_W + 1)'(len_q);

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ov_d = 1'b1; kind_d = KIND_DONE; ob_d = '0; last_d = 1'b1;
          sc_d = '0; em_d = '0;
          unique case (action_e'(action_i))
            ACT_CMD: begin
              if (command_length_i >= LEN_W'(RING_BYTES)) begin
                dead_d = dead_q | live;
                em_d = live;
                kind_d = (live != '0) ? KIND_EVICT : KIND_DONE;
                rd_ptr_d = '0; wr_ptr_d = '0; fill_d = '0; base_d = head_q;
              end else if (command_length_i != '0) begin
                ov_d = 1'b0;
                len_d = command_length_i;
                after_d = head_q + OFS_W'(command_length_i);
                idx_d = '0; macc_d = '0; any_live_d = 1'b0; any_pres_d = 1'b0;
                min_d = '0;
                state_d = ST_SCAN;
              end
            end
            ACT_BYTE: begin
              ram_we = 1'b1;
              if (fill_q >= FILL_W'(RING_BYTES)) begin
                rd_ptr_d = rd_ptr_q + PTR_W'(1);
                base_d = base_q + OFS_W'(1);
              end else begin
                fill_d = fill_q + FILL_W'(1);
              end
              wr_ptr_d = wr_ptr_q + PTR_W'(1);
              head_d = head_q + OFS_W'(1);
            end
            ACT_DRAIN: begin
              if (pres_q[reader_i] && !dead_q[reader_i]) begin
                if (acc_r < base_q) begin
                  dead_d[reader_i] = 1'b1;
                  kind_d = KIND_EVICT;
                  em_d[reader_i] = 1'b1;
                end else if (acc_r < head_q) begin
                  ov_d = 1'b0;
                  n_d = (lag < OFS_W'(lim)) ? lag[LIM_W-1:0] : lim;
                  k_d = '0;
                  pos_d = rd_ptr_q + skip[PTR_W-1:0];
                  rsel_d = reader_i;
                  state_d = ST_DRD;
                end
              end
            end
            ACT_ATTACH: begin
              pres_d[reader_i] = 1'b1; acked_d[reader_i] = offset_value_i;
              rep_d[reader_i] = '0; stream_d[reader_i] = 1'b0; dead_d[reader_i] = 1'b0;
            end
            ACT_STREAM: begin
              if (pres_q[reader_i]) begin
                stream_d[reader_i] = 1'b1;
              end
            end
            ACT_DETACH: begin
              pres_d[reader_i] = 1'b0; acked_d[reader_i] = '0;
              rep_d[reader_i] = '0; stream_d[reader_i] = 1'b0; dead_d[reader_i] = 1'b0;
            end
            ACT_REPORT: begin
              if (pres_q[reader_i]) begin
                rep_d[reader_i] = offset_value_i;
              end
            end
            ACT_COUNT: begin
              ov_d = 1'b0;
              ofs_d = offset_value_i; idx_d = '0; cacc_d = '0;
              state_d = ST_CNT;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (pres_q[idx_q]) begin
          any_pres_d = 1'b1;
        end
        if (live[idx_q]) begin
          if (lagk > OFS_W'(RING_BYTES)) begin
            dead_d[idx_q] = 1'b1;
            macc_d[idx_q] = 1'b1;
          end else if (!any_live_q || acked_q[idx_q] < min_q) begin
            min_d = acked_q[idx_q];
            any_live_d = 1'b1;
          end
        end
        idx_d = idx_q + RIDX_W'(1);
        if (idx_q == RIDX_W'(READERS - 1)) begin
          state_d = ST_COMP1;
        end
      end
      ST_COMP1: begin
        if (!any_pres_q) begin
          drop = fill_q;
        end else if (any_live_q && min_q > base_q) begin
          drop = (dlt > OFS_W'(fill_q)) ? fill_q : dlt[FILL_W-1:0];
        end
        rd_ptr_d = rd_ptr_q + drop[PTR_W-1:0];
        fill_d = fill_q - drop;
        base_d = base_q + OFS_W'(drop);
        state_d = ST_COMP2;
      end
      ST_COMP2: begin
        if (can_put) begin
          if (sum > (LEN_W + 1)'(RING_BYTES)) begin
            drop = FILL_W'(sum - (LEN_W + 1)'(RING_BYTES));
          end
          rd_ptr_d = rd_ptr_q + drop[PTR_W-1:0];
          fill_d = fill_q - drop;
          base_d = base_q + OFS_W'(drop);
          ov_d = 1'b1; kind_d = (macc_q != '0) ? KIND_EVICT : KIND_DONE;
          ob_d = '0; last_d = 1'b1; sc_d = '0; em_d = macc_q;
          state_d = ST_IDLE;
        end
      end
      ST_CNT: begin
        if (pres_q[idx_q] && rep_q[idx_q] >= ofs_q) begin
          cacc_d = cacc_q + CNT_W'(1);
        end
        idx_d = idx_q + RIDX_W'(1);
        if (idx_q == RIDX_W'(READERS - 1)) begin
          state_d = ST_CRESP;
        end
      end
      ST_CRESP: begin
        if (can_put) begin
          ov_d = 1'b1; kind_d = KIND_COUNT; ob_d = '0; last_d = 1'b1;
          sc_d = cacc_q; em_d = '0;
          state_d = ST_IDLE;
        end
      end
      ST_DRD: begin
        if (can_put) begin
          ram_re = 1'b1;
          pos_d = pos_q + PTR_W'(1);
          state_d = ST_DLAT;
        end
      end
      ST_DLAT: begin
        ov_d = 1'b1; kind_d = KIND_DATA; ob_d = ram_rdata; sc_d = '0; em_d = '0;
        last_d = (k_q + LIM_W'(1) == n_q);
        k_d = k_q + LIM_W'(1);
        if (k_q + LIM_W'(1) == n_q) begin
          acked_d[rsel_q] = acked_q[rsel_q] + OFS_W'(n_q);
          state_d = ST_IDLE;
        end else begin
          state_d = ST_DRD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; rd_ptr_q <= '0; wr_ptr_q <= '0; fill_q <= '0;
      base_q <= '0; head_q <= '0;
      for (int i = 0; i < READERS; i++) begin
        acked_q[i] <= '0;
        rep_q[i] <= '0;
      end
      stream_q <= '0; dead_q <= '0; pres_q <= '0;
      limit_q <= LIM_W'(LIMIT_MAX);
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d; rd_ptr_q <= rd_ptr_d; wr_ptr_q <= wr_ptr_d; fill_q <= fill_d;
      base_q <= base_d; head_q <= head_d; acked_q <= acked_d; rep_q <= rep_d;
      stream_q <= stream_d; dead_q <= dead_d; pres_q <= pres_d; limit_q <= limit_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; rsel_q <= rsel_d; len_q <= len_d; after_q <= after_d;
    min_q <= min_d; ofs_q <= ofs_d; any_live_q <= any_live_d; any_pres_q <= any_pres_d;
    macc_q <= macc_d; cacc_q <= cacc_d; n_q <= n_d; k_q <= k_d; pos_q <= pos_d;
    kind_q <= kind_d; ob_q <= ob_d; last_q <= last_d; sc_q <= sc_d; em_q <= em_d;
  end

  mrrb_ram #(.Width(8), .Depth(RING_BYTES)) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_ptr_q),
    .wdata_i (data_byte_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o    = ov_q;
  assign kind_o         = kind_q;
  assign out_byte_o     = ob_q;
  assign last_o         = last_q;
  assign synced_count_o = sc_q;
  assign evicted_mask_o = em_q;

  `MRRB_ASSERT(a_ptr_fill, ((rd_ptr_q + fill_q[PTR_W-1:0]) == wr_ptr_q), "ring pointers disagree")
  `MRRB_ASSERT_ALWAYS(a_fill_max, (fill_q <= FILL_W'(RING_BYTES)), "ring overfilled")
  `MRRB_ASSERT(a_drain_cnt, ((state_q == ST_DLAT) |-> (k_q < n_q)), "drain count overrun")
  `MRRB_ASSERT(a_wr_idle, (ram_we |-> (state_q == ST_IDLE)), "ring written while busy")
endmodule

@@ sim/tb_multi_reader_ring_backlog.sv @@
`timescale 1ns / 1ps
module tb_multi_reader_ring_backlog;
  import mrrb_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;

  typedef struct {
    kind_e      kind;
    logic [7:0] data_v;
    logic       last;
    logic [3:0] cnt;
    logic [7:0] mask;
  } result_t;

  typedef struct {
    action_e     act;
    logic [2:0]  rdr;
    logic [7:0]  data_v;
    logic [19:0] len;
    logic [47:0] ofs;
    bit          typed;
    kind_e       kind;
    logic [3:0]  cnt;
    logic [7:0]  mask;
  } row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [2:0]        action_i = '0;
  logic [2:0]        reader_i = '0;
  logic [7:0]        data_byte_i = '0;
  logic [LEN_W-1:0]  command_length_i = '0;
  logic [OFS_W-1:0]  offset_value_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [1:0]        kind_o;
  logic [7:0]        out_byte_o;
  logic              last_o;
  logic [CNT_W-1:0]  synced_count_o;
  logic [READERS-1:0] evicted_mask_o;
  logic              cfg_we_i = 1'b0;
  logic [LIM_W-1:0]  cfg_wdata_i = '0;

  multi_reader_ring_backlog dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .action_i, .reader_i, .data_byte_i,
    .command_length_i, .offset_value_i, .out_valid_o, .out_ready_i, .kind_o,
    .out_byte_o, .last_o, .synced_count_o, .evicted_mask_o, .cfg_we_i, .cfg_wdata_i
  );

  always #6 clk_i = ~clk_i;

  // Shadow state of the backlog.
  logic [7:0]  ring_q [RING_BYTES];
  int unsigned rd_ptr, wr_ptr, fill;
  logic [47:0] base_ofs, head_ofs;
  logic [47:0] acked [READERS];
  logic [47:0] reported [READERS];
  bit          streaming [READERS];
  bit          dead [READERS];
  bit          present [READERS];
  int unsigned drain_lim;

  result_t pending_results [$];
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_evictions = 0;
  int cycles = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 0;
  int hold_left = 0;

  function automatic bit live(int i);
    return present[i] && !dead[i] && streaming[i];
  endfunction

  function automatic void drop_front(int unsigned n);
    rd_ptr = (rd_ptr + n) % RING_BYTES;
    fill -= n;
    base_ofs += 48'(n);
  endfunction

  function automatic logic [7:0] start_cmd(logic [19:0] len);
    logic [7:0]  m;
    logic [47:0] after, min_ack;
    bit          any_present, any_live;
    longint unsigned drop;
    m = '0;
    any_present = 0;
    any_live = 0;
    min_ack = '0;
    if (len == 0) return m;
    if (len >= RING_BYTES) begin
      for (int i = 0; i < READERS; i++)
        if (live(i)) begin
          dead[i] = 1;
          m[i] = 1'b1;
        end
      rd_ptr = 0;
      wr_ptr = 0;
      fill = 0;
      base_ofs = head_ofs;
      return m;
    end
    after = head_ofs + 48'(len);
    for (int i = 0; i < READERS; i++)
      if (live(i) && (after - acked[i]) > 48'(RING_BYTES)) begin
        dead[i] = 1;
        m[i] = 1'b1;
      end
    for (int i = 0; i < READERS; i++) begin
      if (present[i]) any_present = 1;
      if (live(i) && (!any_live || acked[i] < min_ack)) begin
        min_ack = acked[i];
        any_live = 1;
      end
    end
    if (!any_present) drop_front(fill);
    else if (any_live && min_ack > base_ofs) begin
      drop = 64'(min_ack - base_ofs);
      if (drop > fill) drop = fill;
      drop_front(int'(drop));
    end
    if (longint'(fill) + longint'(len) > RING_BYTES)
      drop_front(int'(longint'(fill) + longint'(len) - RING_BYTES));
    return m;
  endfunction

  function automatic void push_result(kind_e k, logic [7:0] d, logic l, logic [3:0] c,
                                      logic [7:0] m);
    result_t e;
    e.kind = k;
    e.data_v = d;
    e.last = l;
    e.cnt = c;
    e.mask = m;
    pending_results.push_back(e);
  endfunction

  // Works out the result items of one accepted item and advances the shadow state.
  function automatic void predict_backlog(action_e a, logic [2:0] r, logic [7:0] b,
                                          logic [19:0] len, logic [47:0] ofs);
    logic [7:0]  m;
    int unsigned c, lim, n, pos;
    logic [47:0] lag, skip;
    case (a)
      ACT_CMD: begin
        m = start_cmd(len);
        push_result(m != 0 ? KIND_EVICT : KIND_DONE, 8'd0, 1'b1, 4'd0, m);
        return;
      end
      ACT_BYTE: begin
        if (fill >= RING_BYTES) drop_front(1);
        ring_q[wr_ptr] = b;
        wr_ptr = (wr_ptr + 1) % RING_BYTES;
        fill++;
        head_ofs += 48'd1;
      end
      ACT_DRAIN: begin
        if (present[r] && !dead[r]) begin
          if (acked[r] < base_ofs) begin
            dead[r] = 1;
            m = '0;
            m[r] = 1'b1;
            push_result(KIND_EVICT, 8'd0, 1'b1, 4'd0, m);
            return;
          end
          if (acked[r] < head_ofs) begin
            lag = head_ofs - acked[r];
            lim = drain_lim;
            if (lim < 1) lim = 1;
            if (lim > LIMIT_MAX) lim = LIMIT_MAX;
            n = (lag < 48'(lim)) ? int'(lag) : lim;
            skip = acked[r] - base_ofs;
            if (skip > 48'(fill)) skip = 48'(fill);
            pos = (rd_ptr + int'(skip)) % RING_BYTES;
            for (int k = 0; k < n; k++) begin
              push_result(KIND_DATA, ring_q[pos], k + 1 == n, 4'd0, 8'd0);
              pos = (pos + 1) % RING_BYTES;
            end
            acked[r] += 48'(n);
            return;
          end
        end
      end
      ACT_ATTACH: begin
        present[r] = 1;
        acked[r] = ofs;
        reported[r] = '0;
        streaming[r] = 0;
        dead[r] = 0;
      end
      ACT_STREAM: if (present[r]) streaming[r] = 1;
      ACT_DETACH: begin
        present[r] = 0;
        acked[r] = '0;
        reported[r] = '0;
        streaming[r] = 0;
        dead[r] = 0;
      end
      ACT_REPORT: if (present[r]) reported[r] = ofs;
      default: begin
        c = 0;
        for (int i = 0; i < READERS; i++)
          if (present[i] && reported[i] >= ofs) c++;
        push_result(KIND_COUNT, 8'd0, 1'b1, 4'(c), 8'd0);
        return;
      end
    endcase
    push_result(KIND_DONE, 8'd0, 1'b1, 4'd0, 8'd0);
  endfunction

  task automatic report_mismatch(string what, longint unsigned exp_v, longint unsigned got_v);
    $display("mismatch at result %0d: %s expected %0h got %0h", n_results, what, exp_v, got_v);
    errors++;
  endtask

  // Results are compared on the falling edge before the rising edge that takes them.
  always @(negedge clk_i) begin
    result_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item, kind", 0, kind_o);
      end else begin
        e = pending_results.pop_front();
        if (kind_o != e.kind) report_mismatch("kind", e.kind, kind_o);
        if (out_byte_o != e.data_v) report_mismatch("out_byte", e.data_v, out_byte_o);
        if (last_o != e.last) report_mismatch("last", e.last, last_o);
        if (synced_count_o != e.cnt) report_mismatch("synced_count", e.cnt, synced_count_o);
        if (evicted_mask_o != e.mask) report_mismatch("evicted_mask", e.mask, evicted_mask_o);
        if (e.kind == KIND_EVICT) n_evictions++;
      end
      n_results++;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_req) begin
      hold_req = 0;
      hold_left = 400;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_multi_reader_ring_backlog: FAIL");
      $finish;
    end
  end

  task automatic send_item(action_e a, logic [2:0] r, logic [7:0] b, logic [19:0] len,
                           logic [47:0] ofs);
    bit fire;
    in_valid_i <= 1'b1;
    action_i <= a;
    reader_i <= r;
    data_byte_i <= b;
    command_length_i <= len;
    offset_value_i <= ofs;
    do begin
      @(negedge clk_i);
      fire = in_ready_o;
      @(posedge clk_i);
    end while (!fire);
    predict_backlog(a, r, b, len, ofs);
    n_items++;
  endtask

  task automatic maybe_gap();
    if (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0 && guard < 200_000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [LIM_W-1:0] v);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    drain_lim = v;
  endtask

  function automatic logic [47:0] rand_ofs();
    return {16'($urandom), $urandom};
  endfunction

  function automatic logic [47:0] near_head();
    return head_ofs - 48'($urandom_range(0, 200));
  endfunction

  task automatic random_item();
    int sel;
    logic [2:0] r;
    logic [19:0] len;
    sel = $urandom_range(99);
    r = 3'($urandom_range(7));
    if (sel < 35) begin
      send_item(ACT_BYTE, r, 8'($urandom), 20'($urandom), rand_ofs());
    end else if (sel < 55) begin
      send_item(ACT_DRAIN, r, 8'($urandom), 20'($urandom), rand_ofs());
    end else if (sel < 63) begin
      case ($urandom_range(19))
        0: len = 20'd0;
        1: len = 20'($urandom);
        2: len = 20'($urandom_range(4000, 4200));
        default: len = 20'($urandom_range(1, 64));
      endcase
      send_item(ACT_CMD, r, 8'($urandom), len, rand_ofs());
    end else if (sel < 71) begin
      send_item(ACT_ATTACH, r, 8'($urandom), 20'($urandom),
                $urandom_range(9) == 0 ? rand_ofs() : near_head());
    end else if (sel < 79) begin
      send_item(ACT_STREAM, r, 8'($urandom), 20'($urandom), rand_ofs());
    end else if (sel < 84) begin
      send_item(ACT_DETACH, r, 8'($urandom), 20'($urandom), rand_ofs());
    end else if (sel < 92) begin
      send_item(ACT_REPORT, r, 8'($urandom), 20'($urandom),
                $urandom_range(3) == 0 ? rand_ofs() : near_head());
    end else begin
      send_item(ACT_COUNT, r, 8'($urandom), 20'($urandom),
                $urandom_range(3) == 0 ? rand_ofs() : near_head());
    end
  endtask

  row_t dir_rows [$];

  task automatic add_row(action_e a, logic [2:0] r, logic [7:0] b, logic [19:0] len,
                         logic [47:0] ofs, bit typed = 0, kind_e k = KIND_DONE,
                         logic [3:0] c = '0, logic [7:0] m = '0);
    row_t row;
    row.act = a;
    row.rdr = r;
    row.data_v = b;
    row.len = len;
    row.ofs = ofs;
    row.typed = typed;
    row.kind = k;
    row.cnt = c;
    row.mask = m;
    dir_rows.push_back(row);
  endtask

  initial begin
    logic [LIM_W-1:0] limits [8];
    rd_ptr = 0;
    wr_ptr = 0;
    fill = 0;
    base_ofs = '0;
    head_ofs = '0;
    drain_lim = LIMIT_MAX;
    for (int i = 0; i < READERS; i++) begin
      acked[i] = '0;
      reported[i] = '0;
      streaming[i] = 0;
      dead[i] = 0;
      present[i] = 0;
    end
    for (int i = 0; i < RING_BYTES; i++) ring_q[i] = '0;

    add_row(ACT_COUNT, 3'd0, 8'h00, 20'd0, 48'd0, 1, KIND_COUNT, 4'd0);
    add_row(ACT_CMD, 3'd0, 8'h00, 20'd0, 48'd0, 1, KIND_DONE);
    add_row(ACT_ATTACH, 3'd0, 8'h00, 20'd0, 48'd0, 1, KIND_DONE);
    add_row(ACT_ATTACH, 3'd7, 8'h00, 20'd0, 48'd0, 1, KIND_DONE);
    add_row(ACT_STREAM, 3'd0, 8'h00, 20'd0, 48'd0, 1, KIND_DONE);
    add_row(ACT_STREAM, 3'd7, 8'h00, 20'd0, 48'd0, 1, KIND_DONE);
    add_row(ACT_BYTE, 3'd0, 8'h00, 20'd0, 48'd0, 1, KIND_DONE);
    add_row(ACT_BYTE, 3'd0, 8'hFF, 20'd0, 48'd0, 1, KIND_DONE);
    add_row(ACT_BYTE, 3'd0, 8'hA5, 20'd0, 48'd0, 1, KIND_DONE);
    add_row(ACT_DRAIN, 3'd0, 8'h00, 20'd0, 48'd0);
    add_row(ACT_REPORT, 3'd0, 8'h00, 20'd0, 48'hFFFF_FFFF_FFFF, 1, KIND_DONE);
    add_row(ACT_COUNT, 3'd0, 8'h00, 20'd0, 48'hFFFF_FFFF_FFFF, 1, KIND_COUNT, 4'd1);
    add_row(ACT_DRAIN, 3'd3, 8'h00, 20'd0, 48'd0, 1, KIND_DONE);
    add_row(ACT_STREAM, 3'd3, 8'h00, 20'd0, 48'd0, 1, KIND_DONE);
    add_row(ACT_REPORT, 3'd3, 8'h00, 20'd0, 48'd5, 1, KIND_DONE);
    add_row(ACT_CMD, 3'd0, 8'h00, 20'hFFFFF, 48'd0, 1, KIND_EVICT, 4'd0, 8'h81);
    add_row(ACT_DRAIN, 3'd7, 8'h00, 20'd0, 48'd0, 1, KIND_DONE);
    add_row(ACT_ATTACH, 3'd1, 8'h00, 20'd0, 48'h8000_0000_0000, 1, KIND_DONE);
    add_row(ACT_STREAM, 3'd1, 8'h00, 20'd0, 48'd0, 1, KIND_DONE);
    add_row(ACT_CMD, 3'd0, 8'h00, 20'd1, 48'd0, 1, KIND_EVICT, 4'd0, 8'h02);
    add_row(ACT_ATTACH, 3'd2, 8'h00, 20'd0, 48'd0, 1, KIND_DONE);
    add_row(ACT_DRAIN, 3'd2, 8'h00, 20'd0, 48'd0, 1, KIND_EVICT, 4'd0, 8'h04);
    add_row(ACT_DETACH, 3'd2, 8'h00, 20'd0, 48'd0, 1, KIND_DONE);
    add_row(ACT_ATTACH, 3'd4, 8'h00, 20'd0, 48'd3, 1, KIND_DONE);
    add_row(ACT_DRAIN, 3'd4, 8'h00, 20'd0, 48'd0, 1, KIND_DONE);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].act, dir_rows[i].rdr, dir_rows[i].data_v, dir_rows[i].len,
                dir_rows[i].ofs);
      if (dir_rows[i].typed) begin
        void'(pending_results.pop_back());
        push_result(dir_rows[i].kind, 8'd0, 1'b1, dir_rows[i].cnt, dir_rows[i].mask);
      end
    end

    limits = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd7, 7'd33, 7'd100, 7'd64};
    for (int p = 0; p < 8; p++) begin
      write_limit(limits[p]);
      case (p % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 50; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 50; end
        default: begin send_gap_pct = 19; recv_stall_pct = 19; end
      endcase
      for (int s = 0; s < 3; s++) begin
        send_item(ACT_ATTACH, 3'(s + p), 8'd0, 20'd0, near_head());
        send_item(ACT_STREAM, 3'(s + p), 8'd0, 20'd0, 48'd0);
      end
      if (p == 1) hold_req = 1;
      for (int k = 0; k < 48; k++) begin
        random_item();
        maybe_gap();
        if (p == 2 && k == 24) wait_drained();
      end
    end

    wait_drained();
    $display("covered %0d items and %0d result items, %0d of them evictions,",
             n_items, n_results, n_evictions);
    $display("over eight drain limit settings and four idling patterns");
    if (errors == 0) begin
      $display("tb_multi_reader_ring_backlog: PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb_multi_reader_ring_backlog: FAIL");
    end
    $finish;
  end
endmodule
